### rtl/core/itb_pkg.sv
// Shared types, constants and command codes for the interval timer bank.
// No dependencies; compiled first.
package itb_pkg;

  localparam int ITB_NUM_TIMERS = 4;

  localparam int SEC_W  = 27;
  localparam int USEC_W = 20;
  localparam int CMD_W  = 2;
  localparam int IDX_FW = 2;
  localparam int RAW_W  = 32;

  localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [USEC_W-1:0] USEC_MAX     = 20'd999999;
  localparam logic [RAW_W-1:0]  MAX_SEC      = 32'd100000000;
  localparam logic [USEC_W-1:0] TICK_RESET   = 20'd10000;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic [SEC_W-1:0]  rem_sec;
    logic [USEC_W-1:0] rem_usec;
    logic [SEC_W-1:0]  rld_sec;
    logic [USEC_W-1:0] rld_usec;
  } timer_t;

endpackage

### rtl/core/itb_if.sv
// Valid/ready channel interfaces for the interval timer bank.
// Depends on itb_pkg for field widths.
interface itb_in_if import itb_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic [IDX_FW-1:0]        timer_index;
  logic signed [RAW_W-1:0]  new_value_sec;
  logic signed [RAW_W-1:0]  new_value_usec;
  logic signed [RAW_W-1:0]  new_interval_sec;
  logic signed [RAW_W-1:0]  new_interval_usec;
  logic [USEC_W-1:0]        elapsed_usec;

  modport source (output valid, cmd, timer_index, new_value_sec, new_value_usec,
                  new_interval_sec, new_interval_usec, elapsed_usec, input ready);
  modport sink   (input valid, cmd, timer_index, new_value_sec, new_value_usec,
                  new_interval_sec, new_interval_usec, elapsed_usec, output ready);
endinterface

interface itb_out_if import itb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              status;
  logic              expired;
  logic [SEC_W-1:0]  out_value_sec;
  logic [USEC_W-1:0] out_value_usec;
  logic [SEC_W-1:0]  out_interval_sec;
  logic [USEC_W-1:0] out_interval_usec;

  modport source (output valid, status, expired, out_value_sec, out_value_usec,
                  out_interval_sec, out_interval_usec, input ready);
  modport sink   (input valid, status, expired, out_value_sec, out_value_usec,
                  out_interval_sec, out_interval_usec, output ready);
endinterface

### rtl/core/interval_timer_bank_top.sv
// Interval timer bank top level: timer state memory, load/tick/read datapath.
// Depends on itb_pkg and the channel interfaces in itb_if.sv.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      cmd, timer_index, new value/interval, elapsed_usec
//  out_ch    out  valid/ready      status, expired, value and interval
//  cfg_*     in   cfg_we           cfg_wdata -> tick_r
//
// An accepted transaction moves through the stage-1 registers into the result
// register; one transaction per cycle is sustained while results are taken, set by the single read and write port of
// the timer memory, with the write of the previous transaction forwarded.
// Reset clears per-timer valid bits at once; an unwritten timer reads as zero.
// A stalled result holds the pipeline; the memory read data holds with it.
module interval_timer_bank_top
  import itb_pkg::*;
#(
  parameter int NUM_TIMERS = ITB_NUM_TIMERS
) (
  input  logic              clk,
  input  logic              rst_n,
  itb_in_if.sink            in_ch,
  itb_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [USEC_W-1:0] cfg_wdata
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int IXE_W = (IDX_W > IDX_FW) ? IDX_W : IDX_FW;

  function automatic logic part_ok(logic [RAW_W-1:0] s, logic [RAW_W-1:0] u);
    return !s[RAW_W-1] && (s <= MAX_SEC) && !u[RAW_W-1] &&
           (u < RAW_W'(USEC_PER_SEC));
  endfunction

  function automatic logic [USEC_W-1:0] round_usec(logic [SEC_W-1:0] s,
                                                   logic [USEC_W-1:0] u,
                                                   logic [USEC_W-1:0] t);
    return (s == '0 && u != '0 && u < t) ? t : u;
  endfunction

  // configuration
  logic [USEC_W-1:0] tick_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_RESET;
    end else if (cfg_we) begin
      tick_r <= cfg_wdata;
    end
  end

  // timer memory
  timer_t            mem [NUM_TIMERS];
  timer_t            rd_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;
  timer_t            mem_wd;

  // pipeline control and stage-1 item
  logic              s1_vld_r;
  logic              s1_adv;
  logic              in_acc;
  logic [CMD_W-1:0]  s1_cmd_r;
  logic [IDX_W-1:0]  s1_addr_r;
  logic              s1_range_r;
  logic [RAW_W-1:0]  s1_vs_r, s1_vu_r, s1_is_r, s1_iu_r;
  logic [USEC_W-1:0] s1_e_r;
  logic              fwd_hit_r;
  timer_t            fwd_data_r;
  logic              ent_vld_hit_r;
  logic [NUM_TIMERS-1:0] ent_vld_r;

  logic [IXE_W-1:0]  in_idx_ext;
  logic [IDX_W-1:0]  in_addr;
  logic              in_range;

  assign in_idx_ext = IXE_W'(in_ch.timer_index);
  assign in_addr    = in_idx_ext[IDX_W-1:0];
  assign in_range   = 32'(in_ch.timer_index) < NUM_TIMERS;

  logic out_vld_r;

  assign s1_adv      = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !s1_vld_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= mem[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      ent_vld_r <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (mem_we) begin
        ent_vld_r[mem_wa] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r      <= in_ch.cmd;
      s1_addr_r     <= in_addr;
      s1_range_r    <= in_range;
      s1_vs_r       <= in_ch.new_value_sec;
      s1_vu_r       <= in_ch.new_value_usec;
      s1_is_r       <= in_ch.new_interval_sec;
      s1_iu_r       <= in_ch.new_interval_usec;
      s1_e_r        <= in_ch.elapsed_usec;
      // forward the write landing in this same cycle
      fwd_hit_r     <= mem_we && (mem_wa == in_addr);
      fwd_data_r    <= mem_wd;
      ent_vld_hit_r <= in_range && ent_vld_r[in_addr];
    end
  end

  // stage-1 datapath
  timer_t            cur;
  timer_t            nxt;
  logic [USEC_W-1:0] tick_eff;
  logic [USEC_W-1:0] e_eff;
  logic              load_ok;
  logic              armed;
  logic              fire;
  logic [USEC_W-1:0] over;
  logic [SEC_W-1:0]  rs;
  logic [USEC_W-1:0] ru;
  logic              do_write;
  logic              st_nxt, exp_nxt;

  always_comb begin
    cur      = fwd_hit_r ? fwd_data_r : (ent_vld_hit_r ? rd_r : '0);
    tick_eff = (tick_r > USEC_MAX) ? USEC_MAX : tick_r;
    e_eff    = (s1_e_r > USEC_MAX) ? USEC_MAX : s1_e_r;
    load_ok  = part_ok(s1_vs_r, s1_vu_r) && part_ok(s1_is_r, s1_iu_r);
    armed    = (cur.rem_sec != '0) || (cur.rem_usec != '0);
    nxt      = cur;
    fire     = 1'b0;
    over     = '0;
    rs       = cur.rem_sec;
    ru       = cur.rem_usec;
    do_write = 1'b0;
    st_nxt   = 1'b0;
    exp_nxt  = 1'b0;

    // borrow from seconds, or note the overshoot past zero
    if (ru < e_eff) begin
      if (rs == '0) begin
        over = e_eff - ru;
        fire = 1'b1;
      end else begin
        ru = USEC_W'(({1'b0, ru} + {1'b0, USEC_PER_SEC}) - {1'b0, e_eff});
        rs = rs - SEC_W'(1);
      end
    end else begin
      ru = ru - e_eff;
    end
    if (rs == '0 && ru == '0) begin
      fire = 1'b1;
    end
    if (fire) begin
      // reload less the overshoot, or stop
      if (cur.rld_sec == '0 && cur.rld_usec == '0) begin
        rs = '0;
        ru = '0;
      end else if (cur.rld_usec >= over) begin
        rs = cur.rld_sec;
        ru = cur.rld_usec - over;
      end else if (cur.rld_sec != '0) begin
        rs = cur.rld_sec - SEC_W'(1);
        ru = USEC_W'(({1'b0, cur.rld_usec} + {1'b0, USEC_PER_SEC}) - {1'b0, over});
      end else begin
        rs = '0;
        ru = '0;
      end
    end

    unique case (s1_cmd_r)
      CMD_LOAD: begin
        st_nxt   = !load_ok;
        do_write = load_ok;
        nxt.rem_sec  = s1_vs_r[SEC_W-1:0];
        nxt.rem_usec = round_usec(s1_vs_r[SEC_W-1:0], s1_vu_r[USEC_W-1:0], tick_eff);
        nxt.rld_sec  = s1_is_r[SEC_W-1:0];
        nxt.rld_usec = round_usec(s1_is_r[SEC_W-1:0], s1_iu_r[USEC_W-1:0], tick_eff);
      end
      CMD_TICK: begin
        if (armed) begin
          do_write     = 1'b1;
          exp_nxt      = fire;
          nxt.rem_sec  = rs;
          nxt.rem_usec = ru;
        end
      end
      default: begin
        do_write = 1'b0;
      end
    endcase
  end

  assign mem_we = s1_adv && s1_range_r && do_write;
  assign mem_wa = s1_addr_r;
  assign mem_wd = nxt;

  // result register
  logic              out_st_r, out_exp_r;
  timer_t            out_tm_r;
  timer_t            res_tm;

  always_comb begin
    res_tm = cur;
    if (s1_cmd_r == CMD_TICK) begin
      res_tm.rem_sec  = nxt.rem_sec;
      res_tm.rem_usec = nxt.rem_usec;
    end
    if (!s1_range_r) begin
      res_tm = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_st_r  <= s1_range_r && st_nxt;
      out_exp_r <= s1_range_r && exp_nxt;
      out_tm_r  <= res_tm;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.status            = out_st_r;
  assign out_ch.expired           = out_exp_r;
  assign out_ch.out_value_sec     = out_tm_r.rem_sec;
  assign out_ch.out_value_usec    = out_tm_r.rem_usec;
  assign out_ch.out_interval_sec  = out_tm_r.rld_sec;
  assign out_ch.out_interval_usec = out_tm_r.rld_usec;

  // a new transaction never lands on a stage-1 item that is still held
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && s1_vld_r) |-> s1_adv)
    else $error("stage-1 item overwritten");

  // memory writes come only from an in-range item that moves on
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (s1_vld_r && s1_range_r && s1_adv))
    else $error("memory write without a live item");

  // a rejected load leaves the timer untouched
  a_bad_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_cmd_r == CMD_LOAD && !load_ok) |-> !mem_we)
    else $error("rejected load wrote the memory");

  // a result never reports both expiry and rejection
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(out_st_r && out_exp_r))
    else $error("status and expired both set");

  // a stage-1 item that moves on shows up in the result register next cycle
  a_adv_fill: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("result register not loaded");

endmodule

### tb/itb_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the interval timer bank: keeps its own copy of the timer store and tick length,
// predicts each result transaction from the accepted commands and compares them in order.
// Depends on itb_pkg and the channel interfaces in itb_if.sv.
module itb_checker
  import itb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  itb_in_if                 in_mon,
  itb_out_if                out_mon,
  input  logic              cfg_we,
  input  logic [USEC_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending
);

  localparam int unsigned ONE_SEC_USEC = 32'(USEC_PER_SEC);

  typedef struct packed {
    logic              status;
    logic              expired;
    logic [SEC_W-1:0]  value_sec;
    logic [USEC_W-1:0] value_usec;
    logic [SEC_W-1:0]  intv_sec;
    logic [USEC_W-1:0] intv_usec;
  } timer_report_t;

  timer_t            timers [ITB_NUM_TIMERS];
  logic [USEC_W-1:0] tick_len;
  timer_report_t     expected_reports [$];
  timer_report_t     got, want;
  int                errors;

  function automatic logic setting_ok(logic [RAW_W-1:0] sec, logic [RAW_W-1:0] usec);
    return !sec[RAW_W-1] && sec <= MAX_SEC && !usec[RAW_W-1] && usec < ONE_SEC_USEC;
  endfunction

  // Raise a nonzero sub-tick amount to one tick; the tick saturates below one second.
  function automatic logic [USEC_W-1:0] rounded_usec(logic [RAW_W-1:0] sec,
                                                     logic [RAW_W-1:0] usec);
    logic [USEC_W-1:0] floor_usec;
    floor_usec = (tick_len > USEC_MAX) ? USEC_MAX : tick_len;
    if (sec == '0 && usec != '0 && usec < RAW_W'(floor_usec)) return floor_usec;
    return usec[USEC_W-1:0];
  endfunction

  function automatic timer_report_t advance_timer(logic [CMD_W-1:0] cmd,
                                                  logic [IDX_FW-1:0] idx,
                                                  logic [RAW_W-1:0] vs, logic [RAW_W-1:0] vu,
                                                  logic [RAW_W-1:0] is, logic [RAW_W-1:0] iu,
                                                  logic [USEC_W-1:0] elapsed);
    timer_report_t rep;
    timer_t        cur;
    int unsigned   rs, ru, over, step;
    logic          fire;
    rep = '0;
    if (32'(idx) >= ITB_NUM_TIMERS) return rep;
    cur = timers[idx];
    rep.value_sec  = cur.rem_sec;
    rep.value_usec = cur.rem_usec;
    rep.intv_sec   = cur.rld_sec;
    rep.intv_usec  = cur.rld_usec;
    if (cmd == CMD_LOAD) begin
      if (setting_ok(vs, vu) && setting_ok(is, iu)) begin
        timers[idx].rem_sec  = vs[SEC_W-1:0];
        timers[idx].rem_usec = rounded_usec(vs, vu);
        timers[idx].rld_sec  = is[SEC_W-1:0];
        timers[idx].rld_usec = rounded_usec(is, iu);
      end else begin
        rep.status = 1'b1;
      end
    end else if (cmd == CMD_TICK && (cur.rem_sec != '0 || cur.rem_usec != '0)) begin
      step = 32'((elapsed > USEC_MAX) ? USEC_MAX : elapsed);
      rs   = 32'(cur.rem_sec);
      ru   = 32'(cur.rem_usec);
      over = 0;
      fire = 1'b0;
      // borrow a second, or record how far past zero the tick went
      if (ru < step) begin
        if (rs == 0) begin
          over = step - ru;
          fire = 1'b1;
        end else begin
          ru = ru + ONE_SEC_USEC - step;
          rs = rs - 1;
        end
      end else begin
        ru = ru - step;
      end
      if (rs == 0 && ru == 0) fire = 1'b1;
      if (fire) begin
        rep.expired = 1'b1;
        // reload less the overshoot; stop when no interval or overshoot eats it
        if (cur.rld_sec == '0 && cur.rld_usec == '0) begin
          rs = 0;
          ru = 0;
        end else if (32'(cur.rld_usec) >= over) begin
          rs = 32'(cur.rld_sec);
          ru = 32'(cur.rld_usec) - over;
        end else if (cur.rld_sec != '0) begin
          rs = 32'(cur.rld_sec) - 1;
          ru = 32'(cur.rld_usec) + ONE_SEC_USEC - over;
        end else begin
          rs = 0;
          ru = 0;
        end
      end
      timers[idx].rem_sec  = SEC_W'(rs);
      timers[idx].rem_usec = USEC_W'(ru);
      rep.value_sec        = SEC_W'(rs);
      rep.value_usec       = USEC_W'(ru);
    end
    return rep;
  endfunction

  task automatic check_field(string field, logic [RAW_W-1:0] exp_val, logic [RAW_W-1:0] act_val);
    if (exp_val !== act_val) begin
      if (errors < 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, exp_val, act_val);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ITB_NUM_TIMERS; i++) timers[i] = '0;
      tick_len = TICK_RESET;
      expected_reports.delete();
      errors = 0;
    end else begin
      // compare before pushing: a result never belongs to this edge's command
      if (out_mon.valid && out_mon.ready) begin
        got.status     = out_mon.status;
        got.expired    = out_mon.expired;
        got.value_sec  = out_mon.out_value_sec;
        got.value_usec = out_mon.out_value_usec;
        got.intv_sec   = out_mon.out_interval_sec;
        got.intv_usec  = out_mon.out_interval_usec;
        if (expected_reports.size() == 0) begin
          if (errors < 10) $display("%0t: result with none expected: %p", $realtime, got);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", RAW_W'(want.status), RAW_W'(got.status));
          check_field("expired", RAW_W'(want.expired), RAW_W'(got.expired));
          check_field("value_sec", RAW_W'(want.value_sec), RAW_W'(got.value_sec));
          check_field("value_usec", RAW_W'(want.value_usec), RAW_W'(got.value_usec));
          check_field("interval_sec", RAW_W'(want.intv_sec), RAW_W'(got.intv_sec));
          check_field("interval_usec", RAW_W'(want.intv_usec), RAW_W'(got.intv_usec));
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_reports.push_back(advance_timer(in_mon.cmd, in_mon.timer_index,
                                                 in_mon.new_value_sec, in_mon.new_value_usec,
                                                 in_mon.new_interval_sec,
                                                 in_mon.new_interval_usec,
                                                 in_mon.elapsed_usec));
      if (cfg_we) tick_len = cfg_wdata;
    end
    fail_count <= errors;
    pending    <= expected_reports.size();
  end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps
// Top of the interval timer bank testbench: clock, reset, tick register writes and
// load/tick/read traffic with random idling on both channels; itb_checker does the checking.
// Depends on itb_pkg, itb_if.sv, itb_checker and interval_timer_bank_top.
module tb;
  import itb_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;  // unused code, behaves as a read
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 330;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [USEC_W-1:0] cfg_wdata;
  int                fail_count;
  int                pending;
  // 1-in-N chance of an idle burst, per transaction for send_odds; 0 means no idling
  int                send_odds = 3;
  int                take_odds = 3;

  itb_in_if  in_ch ();
  itb_out_if out_ch ();

  interval_timer_bank_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  itb_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

  initial begin : take_side
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && take_odds != 0 && $urandom_range(1, take_odds) == 1)
        hold = $urandom_range(1, 10);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic issue(input logic [CMD_W-1:0] cmd, input logic [IDX_FW-1:0] idx,
                       input logic [RAW_W-1:0] vs, input logic [RAW_W-1:0] vu,
                       input logic [RAW_W-1:0] is, input logic [RAW_W-1:0] iu,
                       input logic [USEC_W-1:0] elapsed);
    int gap;
    in_ch.valid             <= 1'b1;
    in_ch.cmd               <= cmd;
    in_ch.timer_index       <= idx;
    in_ch.new_value_sec     <= vs;
    in_ch.new_value_usec    <= vu;
    in_ch.new_interval_sec  <= is;
    in_ch.new_interval_usec <= iu;
    in_ch.elapsed_usec      <= elapsed;
    do @(posedge clk); while (!in_ch.ready);
    gap = 0;
    if (send_odds != 0 && $urandom_range(1, send_odds) == 1) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result has drained, then let the pipeline empty.
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_tick(input logic [USEC_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly well-formed small settings so timers expire often; some garbage fields.
  task automatic random_load(input logic [IDX_FW-1:0] idx);
    logic [RAW_W-1:0] f [4];
    for (int k = 0; k < 4; k += 2) begin
      case ($urandom_range(0, 9))
        0:       f[k] = $urandom_range(0, MAX_SEC);
        1, 2:    f[k] = $urandom_range(0, 100);
        3, 4:    f[k] = '0;
        default: f[k] = $urandom_range(0, 2);
      endcase
      f[k+1] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20000)
                                           : $urandom_range(0, USEC_MAX);
    end
    if ($urandom_range(0, 7) == 0) f[$urandom_range(0, 3)] = $urandom;
    issue(CMD_LOAD, idx, f[0], f[1], f[2], f[3], USEC_W'($urandom));
  endtask

  task automatic random_item();
    logic [IDX_FW-1:0] idx;
    int                pick;
    idx  = IDX_FW'($urandom_range(0, ITB_NUM_TIMERS - 1));
    pick = $urandom_range(0, 19);
    if (pick < 5)
      random_load(idx);
    else if (pick < 14)
      issue(CMD_TICK, idx, $urandom, $urandom, $urandom, $urandom,
            USEC_W'($urandom_range(0, USEC_MAX)));
    else if (pick == 14)
      issue(CMD_TICK, idx, $urandom, $urandom, $urandom, $urandom,
            USEC_W'($urandom_range(0, 100)));
    else if (pick == 15)
      issue(CMD_TICK, idx, $urandom, $urandom, $urandom, $urandom, USEC_W'($urandom));
    else
      issue((pick == 19) ? CMD_SPARE : CMD_READ, idx, $urandom, $urandom, $urandom, $urandom,
            USEC_W'($urandom));
  endtask

  initial begin
    rst_n                   <= 1'b0;
    cfg_we                  <= 1'b0;
    cfg_wdata               <= '0;
    in_ch.valid             <= 1'b0;
    in_ch.cmd               <= CMD_READ;
    in_ch.timer_index       <= '0;
    in_ch.new_value_sec     <= '0;
    in_ch.new_value_usec    <= '0;
    in_ch.new_interval_sec  <= '0;
    in_ch.new_interval_usec <= '0;
    in_ch.elapsed_usec      <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset tick length of 10000 us
    issue(CMD_READ, 2'd0, '0, '0, '0, '0, '0);
    issue(CMD_TICK, 2'd0, '0, '0, '0, '0, 20'hFFFFF);             // unarmed timer
    issue(CMD_LOAD, 2'd0, MAX_SEC, RAW_W'(USEC_MAX), MAX_SEC, RAW_W'(USEC_MAX), '0);
    issue(CMD_LOAD, 2'd1, 32'hFFFF_FFFF, '0, 32'd1, '0, '0);       // negative seconds
    issue(CMD_LOAD, 2'd1, MAX_SEC + 1, '0, 32'd1, '0, '0);
    issue(CMD_LOAD, 2'd1, 32'd1, 32'd1000000, 32'd1, '0, '0);
    issue(CMD_LOAD, 2'd1, 32'd1, '0, 32'd1, 32'h8000_0000, '0);
    issue(CMD_LOAD, 2'd1, 32'd1, '0, MAX_SEC + 1, '0, '0);
    issue(CMD_LOAD, 2'd1, '0, 32'd1, '0, 32'd9999, '0);            // both raised to one tick
    issue(CMD_TICK, 2'd1, '0, '0, '0, '0, 20'd10000);               // lands exactly on zero
    issue(CMD_TICK, 2'd1, '0, '0, '0, '0, 20'hFFFFF);               // overshoot beyond interval
    issue(CMD_LOAD, 2'd2, '0, 32'd500000, 32'd2, 32'd100, '0);
    issue(CMD_TICK, 2'd2, '0, '0, '0, '0, 20'd700000);              // reload with a borrow
    issue(CMD_LOAD, 2'd3, 32'd1, '0, '0, '0, '0);
    issue(CMD_TICK, 2'd3, '0, '0, '0, '0, 20'd1);                   // borrow a second
    issue(CMD_TICK, 2'd3, '0, '0, '0, '0, USEC_MAX);                // expire, no reload
    issue(CMD_LOAD, 2'd2, '0, '0, '0, '0, '0);
    issue(CMD_LOAD, 2'd0, '0, '0, 32'd3, 32'd5, '0);
    issue(CMD_SPARE, 2'd0, '0, '0, '0, '0, '0);
    issue(CMD_READ, 2'd2, '0, '0, '0, '0, '0);
    issue(CMD_TICK, 2'd0, '0, '0, '0, '0, '0);
    issue(CMD_LOAD, 2'd1, 32'd5, RAW_W'(USEC_MAX), 32'd1, '0, '0);
    issue(CMD_TICK, 2'd1, '0, '0, '0, '0, '0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       write_tick(20'd1);
        1:       write_tick(USEC_MAX);
        2:       write_tick(20'hFFFFF);
        3:       write_tick(20'd0);
        default: write_tick(USEC_W'($urandom_range(1, USEC_MAX)));
      endcase
      send_odds = (p == 2 || p == PHASES - 1) ? 0 : 2 + p;
      take_odds = send_odds;
      repeat (PHASE_ITEMS) random_item();
      settle();
    end

    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

### filelist.f
rtl/core/itb_pkg.sv
rtl/core/itb_if.sv
rtl/core/interval_timer_bank_top.sv
tb/itb_checker.sv
tb/tb.sv
